@@ hw/rtl/dxt_pkg.sv @@
package dxt_pkg;

	// Block format register codes
	localparam logic [1:0] FMT_DXT1 = 2'd0;
	localparam logic [1:0] FMT_DXT3 = 2'd1;
	localparam logic [1:0] FMT_DXT5 = 2'd2;

	localparam int unsigned PIX_COUNT = 16;
	localparam logic [3:0] PIX_LAST = 4'(PIX_COUNT - 1);

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	// Raw compressed block as captured at the input
	typedef struct packed {
		logic [63:0] cblk;
		logic [63:0] ablk;
		logic [1:0]  fmt;
	} blk_raw_t;

	// Fully built palettes plus the per-pixel indices of one block
	typedef struct packed {
		rgba_t [3:0]       col;
		logic [7:0][7:0]   apal;
		logic [15:0][1:0]  cidx;
		logic [15:0][3:0]  anib;
		logic [15:0][2:0]  aidx;
		logic [1:0]        fmt;
	} blk_pal_t;

endpackage

@@ hw/rtl/dxt_block_decoder_core.sv @@
// Channel   Dir  Handshake            Word
// -------   ---  -------------------  ----------------------------------------
// in        in   in_valid / in_stall  color_block, alpha_block (one 4x4 block)
// out       out  out_valid/out_stall  red, green, blue, alpha, pixel_index, last
// cfg       in   cfg_we               cfg_wdata -> block_format
//
// One block in yields sixteen pixel words out, one per cycle while out_stall is low;
// the emitter takes the next block only after its counter has walked all sixteen.
// The first pixel of a block passes the input register, sum stage, palette stage,
// emitter and output register in that order.
// Reset clears all valid bits, the pixel counter and block_format (DXT1).
// out_stall holds the output word; the stall backs up stage by stage to
// in_stall, and no word is lost or repeated.
module dxt_block_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] color_block,
	input  logic [63:0] alpha_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [3:0]  pixel_index,
	output logic        last
);
	import dxt_pkg::*;

	logic [1:0] format_q;

	logic       valid_s1;
	blk_raw_t   blk_s1;

	logic       pal_ready, pal_valid;
	blk_pal_t   pal_out;

	logic       valid_s4;
	blk_pal_t   pal_s4;
	logic [3:0] cnt_q;

	logic       valid_s5;
	rgba_t      pix_s5;
	logic [3:0] idx_s5;
	logic       last_s5;

	logic       out_load, emit, s4_free;
	rgba_t      pix_d;
	logic [1:0] ci;

	// Hold the format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_DXT1;
		end else if (cfg_we) begin
			format_q <= cfg_wdata;
		end
	end

	// Input register
	assign in_stall = valid_s1 && !pal_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			blk_s1 <= '{cblk: color_block, ablk: alpha_block, fmt: format_q};
		end
	end

	dxt_palette u_palette (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (pal_ready),
		.in_blk    (blk_s1),
		.out_valid (pal_valid),
		.out_ready (s4_free),
		.out_pal   (pal_out)
	);

	// Pixel emitter: walk the sixteen pixels of the held block
	assign out_load = !valid_s5 || !out_stall;
	assign emit     = valid_s4 && out_load;
	assign s4_free  = !valid_s4 || (emit && cnt_q == PIX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			cnt_q    <= '0;
		end else if (s4_free && pal_valid) begin
			valid_s4 <= 1'b1;
			cnt_q    <= '0;
		end else if (emit && cnt_q == PIX_LAST) begin
			valid_s4 <= 1'b0;
			cnt_q    <= '0;
		end else if (emit) begin
			cnt_q    <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_free && pal_valid) begin
			pal_s4 <= pal_out;
		end
	end

	// Select the pixel colour and its alpha by format
	always_comb begin
		ci    = pal_s4.cidx[cnt_q];
		pix_d = pal_s4.col[ci];
		case (pal_s4.fmt)
			FMT_DXT3: pix_d.a = {pal_s4.anib[cnt_q], pal_s4.anib[cnt_q]};
			FMT_DXT5: pix_d.a = pal_s4.apal[pal_s4.aidx[cnt_q]];
			default:  pix_d.a = pal_s4.col[ci].a;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (out_load) begin
			valid_s5 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_s5  <= pix_d;
			idx_s5  <= cnt_q;
			last_s5 <= cnt_q == PIX_LAST;
		end
	end

	assign out_valid   = valid_s5;
	assign red         = pix_s5.r;
	assign green       = pix_s5.g;
	assign blue        = pix_s5.b;
	assign alpha       = pix_s5.a;
	assign pixel_index = idx_s5;
	assign last        = last_s5;

	// A taken pixel that is not last is followed at once by the next one
	a_pix_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=>
			(out_valid && pixel_index == $past(pixel_index) + 4'd1))
		else $error("pixel sequence broken");

	// Last flag marks exactly pixel fifteen
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (pixel_index == PIX_LAST)))
		else $error("last flag does not match pixel index");

	// Input stalls only when the input register is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && !pal_ready))
		else $error("input stalled while input register empty");

endmodule

@@ hw/rtl/dxt_palette.sv @@
module dxt_palette (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dxt_pkg::blk_raw_t in_blk,
	output logic              out_valid,
	input  logic              out_ready,
	output dxt_pkg::blk_pal_t out_pal
);
	import dxt_pkg::*;

	// floor(x/3) for x < 768
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [20:0] p;
		p = {11'd0, x} * 21'd683;
		return p[18:11];
	endfunction

	// floor(x/7) for x < 1792
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [24:0] p;
		p = {14'd0, x} * 25'd2341;
		return p[21:14];
	endfunction

	// floor(x/5) for x < 1280
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [24:0] p;
		p = {14'd0, x} * 25'd3277;
		return p[21:14];
	endfunction

	// Stage 2: expanded endpoints, weighted sums, mode flags
	logic              valid_s2;
	logic [2:0][7:0]   c0_s2, c1_s2, mid_s2;
	logic [2:0][9:0]   t2_s2, t3_s2;
	logic              cgt_s2;
	logic [7:0]        a0_s2, a1_s2;
	logic [5:0][10:0]  s7_s2;
	logic [3:0][10:0]  s5_s2;
	logic              agt_s2;
	logic [63:0]       cblk_s2, ablk_s2;
	logic [1:0]        fmt_s2;

	// Stage 3: finished palettes
	logic              valid_s3;
	blk_pal_t          pal_s3;

	logic adv_s2, adv_s3;

	logic [15:0]       e0, e1;
	logic [2:0][7:0]   c0_d, c1_d, mid_d;
	logic [2:0][9:0]   t2_d, t3_d;
	logic [7:0]        a0_d, a1_d;
	logic [5:0][10:0]  s7_d;
	logic [3:0][10:0]  s5_d;
	blk_pal_t          pal_d;

	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign in_ready = adv_s2;

	// Widen endpoints and form the interpolation sums
	always_comb begin
		e0 = in_blk.cblk[15:0];
		e1 = in_blk.cblk[31:16];
		c0_d[0] = {e0[15:11], 3'b000};
		c0_d[1] = {e0[10:5], 2'b00};
		c0_d[2] = {e0[4:0], 3'b000};
		c1_d[0] = {e1[15:11], 3'b000};
		c1_d[1] = {e1[10:5], 2'b00};
		c1_d[2] = {e1[4:0], 3'b000};
		for (int k = 0; k < 3; k++) begin
			t2_d[k]  = {1'b0, c0_d[k], 1'b0} + {2'b00, c1_d[k]};
			t3_d[k]  = {2'b00, c0_d[k]} + {1'b0, c1_d[k], 1'b0};
			mid_d[k] = 8'(({1'b0, c0_d[k]} + {1'b0, c1_d[k]}) >> 1);
		end
		a0_d = in_blk.ablk[7:0];
		a1_d = in_blk.ablk[15:8];
		for (int k = 1; k <= 6; k++) begin
			s7_d[k-1] = 11'(7 - k) * {3'd0, a0_d} + 11'(k) * {3'd0, a1_d};
		end
		for (int k = 1; k <= 4; k++) begin
			s5_d[k-1] = 11'(5 - k) * {3'd0, a0_d} + 11'(k) * {3'd0, a1_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && in_valid) begin
			c0_s2   <= c0_d;
			c1_s2   <= c1_d;
			mid_s2  <= mid_d;
			t2_s2   <= t2_d;
			t3_s2   <= t3_d;
			cgt_s2  <= e0 > e1;
			a0_s2   <= a0_d;
			a1_s2   <= a1_d;
			s7_s2   <= s7_d;
			s5_s2   <= s5_d;
			agt_s2  <= a0_d > a1_d;
			cblk_s2 <= in_blk.cblk;
			ablk_s2 <= in_blk.ablk;
			fmt_s2  <= in_blk.fmt;
		end
	end

	// Divide the sums and assemble both palettes
	always_comb begin
		pal_d.col[0] = '{r: c0_s2[0], g: c0_s2[1], b: c0_s2[2], a: 8'hff};
		pal_d.col[1] = '{r: c1_s2[0], g: c1_s2[1], b: c1_s2[2], a: 8'hff};
		if (cgt_s2) begin
			pal_d.col[2] = '{r: div3(t2_s2[0]), g: div3(t2_s2[1]),
				b: div3(t2_s2[2]), a: 8'hff};
			pal_d.col[3] = '{r: div3(t3_s2[0]), g: div3(t3_s2[1]),
				b: div3(t3_s2[2]), a: 8'hff};
		end else begin
			pal_d.col[2] = '{r: mid_s2[0], g: mid_s2[1], b: mid_s2[2], a: 8'hff};
			pal_d.col[3] = '{r: 8'h00, g: 8'hff, b: 8'hff, a: 8'h00};
		end
		pal_d.apal[0] = a0_s2;
		pal_d.apal[1] = a1_s2;
		if (agt_s2) begin
			for (int k = 0; k < 6; k++) begin
				pal_d.apal[k+2] = div7(s7_s2[k]);
			end
		end else begin
			for (int k = 0; k < 4; k++) begin
				pal_d.apal[k+2] = div5(s5_s2[k]);
			end
			pal_d.apal[6] = 8'h00;
			pal_d.apal[7] = 8'hff;
		end
		pal_d.cidx = cblk_s2[63:32];
		pal_d.anib = ablk_s2;
		pal_d.aidx = ablk_s2[63:16];
		pal_d.fmt  = fmt_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			pal_s3 <= pal_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_pal   = pal_s3;

endmodule
